// File: rtl/sbus_fd_pkg.sv
// ----------------------------------------------------------------------------
// SBUS frame decoder package
// Shared types and constants for the SBUS frame decoder.
// ----------------------------------------------------------------------------
package sbus_fd_pkg;

    localparam int NUM_CHAN    = 6;
    localparam int NUM_SW      = 4;
    localparam int CHAN_W      = 11;
    localparam int SW_W        = 2;
    localparam int STORE_LEN   = 23;
    localparam int STORE_AW    = 5;
    localparam int IDX_W       = 5;

    localparam logic [7:0] START_BYTE = 8'h0F;
    localparam logic [7:0] END_BYTE   = 8'h00;

    localparam logic [IDX_W-1:0] IDX_FIRST = 5'd0;
    localparam logic [IDX_W-1:0] IDX_LAST  = 5'd24;
    localparam logic [IDX_W-1:0] IDX_IDLE  = 5'd25;

    localparam int FLAG_BYTE = 22;
    localparam int LOST_BIT  = 2;
    localparam int FS_BIT    = 3;

    localparam logic [SW_W-1:0] SW_LOW  = 2'b01;
    localparam logic [SW_W-1:0] SW_MID  = 2'b00;
    localparam logic [SW_W-1:0] SW_HIGH = 2'b11;

    localparam logic [CHAN_W-1:0] RAW_MID = 11'h400;

    localparam int SCALE_MUL   = 1320;
    localparam int ROUND_ADD   = 783;
    localparam int DIV_POS     = 1566;
    localparam int DIV_NEG     = 1568;
    localparam int RECIP_SHIFT = 21;
    localparam int NUM_W       = 21;
    localparam int MAG_W       = 12;
    localparam int QUO_W       = 10;
    localparam int RECIP_W     = 11;
    localparam int DIV_W       = 11;
    localparam int PROD_W      = 32;

    localparam logic [RECIP_W-1:0] RECIP_POS = RECIP_W'((2 ** RECIP_SHIFT) / DIV_POS);
    localparam logic [RECIP_W-1:0] RECIP_NEG = RECIP_W'((2 ** RECIP_SHIFT) / DIV_NEG);

    localparam int MAX_SCALED = 862;

    typedef logic signed [CHAN_W-1:0] chan_t;
    typedef logic signed [SW_W-1:0]   sw_t;

    typedef struct packed {
        chan_t [NUM_CHAN-1:0] chan;
        sw_t   [NUM_SW-1:0]   sw;
        logic                 lost;
        logic                 fs;
    } frame_t;

    typedef struct packed {
        sw_t [NUM_SW-1:0] sw;
        logic             lost;
        logic             fs;
        logic             map_en;
    } side_t;

    typedef struct packed {
        logic s2;
        logic s3;
    } pipe_en_t;

endpackage

// File: rtl/sbus_frame_decoder.sv
// ----------------------------------------------------------------------------
// SBUS frame decoder
// Decodes 25-byte SBUS frames into six stick/knob channels, four switch
// positions and the lost-frame and failsafe flags.
// ----------------------------------------------------------------------------
// Usage:
// - s_ channel: one frame byte per item, s_frame_start on byte 0. Bytes
//   are taken at one per cycle while the result pipeline has room.
// - m_ channel: one item per good frame (start byte 0x0F, end byte 0x00);
//   bad frames and stray bytes give nothing.
// - cfg channel: cfg_map_enable selects scaling of channels 0 to 5 by 660/783
//   or 660/784, up to +/-862; cfg_ready is always high. Write it only while the block is idle.
// - Pipeline: the frame is latched on the edge that accepts byte 24, then it
//   passes the numerator, reciprocal multiply and result register stages;
//   m_valid comes from the result register.
// - Throughput: one byte per cycle while s_ready is high.
// - Stall: with m_ready low the four stages fill, then s_ready drops until
//   the result is taken.
// - Reset: byte counter goes idle awaiting a frame start, pipeline empties,
//   map enable returns to 1.
// ----------------------------------------------------------------------------
module sbus_frame_decoder (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_data_byte,
    input  logic                s_frame_start,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_map_enable,
    output logic                m_valid,
    input  logic                m_ready,
    output sbus_fd_pkg::chan_t  m_chan0,
    output sbus_fd_pkg::chan_t  m_chan1,
    output sbus_fd_pkg::chan_t  m_chan2,
    output sbus_fd_pkg::chan_t  m_chan3,
    output sbus_fd_pkg::chan_t  m_chan4,
    output sbus_fd_pkg::chan_t  m_chan5,
    output sbus_fd_pkg::sw_t    m_switch0,
    output sbus_fd_pkg::sw_t    m_switch1,
    output sbus_fd_pkg::sw_t    m_switch2,
    output sbus_fd_pkg::sw_t    m_switch3,
    output logic                m_lost_frame,
    output logic                m_fail_safe
);

    logic                  map_en_reg;
    logic                  fire;
    logic                  frame_done;
    sbus_fd_pkg::frame_t   frame;

    logic                  v1_reg;
    logic                  v2_reg;
    logic                  v3_reg;
    logic                  v4_reg;
    logic                  rdy1;
    logic                  rdy2;
    logic                  rdy3;
    logic                  rdy4;

    sbus_fd_pkg::chan_t    chan1_reg [sbus_fd_pkg::NUM_CHAN];
    sbus_fd_pkg::side_t    side1_reg;
    sbus_fd_pkg::side_t    side2_reg;
    sbus_fd_pkg::side_t    side3_reg;
    sbus_fd_pkg::pipe_en_t pipe_en;

    sbus_fd_pkg::chan_t    raw3   [sbus_fd_pkg::NUM_CHAN];
    sbus_fd_pkg::chan_t    scaled [sbus_fd_pkg::NUM_CHAN];
    logic                  scale_ok;

    sbus_fd_pkg::chan_t    chan_out_reg [sbus_fd_pkg::NUM_CHAN];
    sbus_fd_pkg::sw_t      sw_out_reg   [sbus_fd_pkg::NUM_SW];
    logic                  lost_out_reg;
    logic                  fs_out_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_en_reg <= 1'b1;
        end else if (cfg_valid) begin
            map_en_reg <= cfg_map_enable;
        end
    end

    assign rdy4    = !v4_reg || m_ready;
    assign rdy3    = !v3_reg || rdy4;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;
    assign s_ready = rdy1;
    assign fire    = s_valid && rdy1;

    sbus_fd_collect u_collect (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .fire        (fire),
        .data_byte   (s_data_byte),
        .frame_start (s_frame_start),
        .done        (frame_done),
        .frame       (frame)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= frame_done;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
            if (rdy4) begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (frame_done) begin
            for (int i = 0; i < sbus_fd_pkg::NUM_CHAN; i++) begin
                chan1_reg[i] <= frame.chan[i];
            end
            side1_reg.sw     <= frame.sw;
            side1_reg.lost   <= frame.lost;
            side1_reg.fs     <= frame.fs;
            side1_reg.map_en <= map_en_reg;
        end
        if (pipe_en.s2) begin
            side2_reg <= side1_reg;
        end
        if (pipe_en.s3) begin
            side3_reg <= side2_reg;
        end
    end

    assign pipe_en.s2 = rdy2 && v1_reg;
    assign pipe_en.s3 = rdy3 && v2_reg;

    for (genvar g = 0; g < sbus_fd_pkg::NUM_CHAN; g++) begin : g_scale
        sbus_fd_scale u_scale (
            .aclk       (aclk),
            .en         (pipe_en),
            .chan_in    (chan1_reg[g]),
            .raw_out    (raw3[g]),
            .scaled_out (scaled[g])
        );
    end

    always_comb begin
        scale_ok = 1'b1;
        for (int i = 0; i < sbus_fd_pkg::NUM_CHAN; i++) begin
            if (scaled[i] > sbus_fd_pkg::chan_t'(sbus_fd_pkg::MAX_SCALED) ||
                scaled[i] < sbus_fd_pkg::chan_t'(-sbus_fd_pkg::MAX_SCALED) ||
                (raw3[i] > 0 && scaled[i] < 0) || (raw3[i] < 0 && scaled[i] > 0)) begin
                scale_ok = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy4 && v3_reg) begin
            for (int i = 0; i < sbus_fd_pkg::NUM_CHAN; i++) begin
                chan_out_reg[i] <= side3_reg.map_en ? scaled[i] : raw3[i];
            end
            for (int s = 0; s < sbus_fd_pkg::NUM_SW; s++) begin
                sw_out_reg[s] <= side3_reg.sw[s];
            end
            lost_out_reg <= side3_reg.lost;
            fs_out_reg   <= side3_reg.fs;
        end
    end

    assign m_valid      = v4_reg;
    assign m_chan0      = chan_out_reg[0];
    assign m_chan1      = chan_out_reg[1];
    assign m_chan2      = chan_out_reg[2];
    assign m_chan3      = chan_out_reg[3];
    assign m_chan4      = chan_out_reg[4];
    assign m_chan5      = chan_out_reg[5];
    assign m_switch0    = sw_out_reg[0];
    assign m_switch1    = sw_out_reg[1];
    assign m_switch2    = sw_out_reg[2];
    assign m_switch3    = sw_out_reg[3];
    assign m_lost_frame = lost_out_reg;
    assign m_fail_safe  = fs_out_reg;

    a_done_enters_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        frame_done |=> v1_reg)
        else $error("completed frame did not enter the pipeline");

    a_result_from_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(v3_reg))
        else $error("result appeared without a frame in the last stage");

    a_scale_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (v3_reg && side3_reg.map_en) |-> scale_ok)
        else $error("scaled channel out of range or wrong sign");

endmodule

// File: rtl/sbus_fd_collect.sv
// ----------------------------------------------------------------------------
// SBUS frame collector
// Counts frame bytes, keeps bytes 1 to 23, checks start and end bytes and
// presents the unpacked frame when a good frame completes.
// ----------------------------------------------------------------------------
module sbus_fd_collect (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 fire,
    input  logic [7:0]           data_byte,
    input  logic                 frame_start,
    output logic                 done,
    output sbus_fd_pkg::frame_t  frame
);

    logic [sbus_fd_pkg::IDX_W-1:0]    byte_index_reg;
    logic [sbus_fd_pkg::IDX_W-1:0]    byte_index_next;
    logic                             start_ok_reg;
    logic [7:0]                       store_reg [sbus_fd_pkg::STORE_LEN];
    logic [sbus_fd_pkg::STORE_AW-1:0] wr_addr;
    logic                             wr_en;
    logic                             start_wr;
    logic [sbus_fd_pkg::STORE_LEN*8-1:0] payload;
    logic [sbus_fd_pkg::CHAN_W-1:0]   raw;

    always_comb begin
        byte_index_next = byte_index_reg;
        wr_en           = 1'b0;
        start_wr        = 1'b0;
        done            = 1'b0;
        wr_addr         = sbus_fd_pkg::STORE_AW'(byte_index_reg - 5'd1);
        if (fire) begin
            if (frame_start || byte_index_reg == sbus_fd_pkg::IDX_FIRST) begin
                start_wr        = 1'b1;
                byte_index_next = 5'd1;
            end else if (byte_index_reg < sbus_fd_pkg::IDX_LAST) begin
                wr_en           = 1'b1;
                byte_index_next = byte_index_reg + 5'd1;
            end else if (byte_index_reg == sbus_fd_pkg::IDX_LAST) begin
                byte_index_next = sbus_fd_pkg::IDX_IDLE;
                done = start_ok_reg && (data_byte == sbus_fd_pkg::END_BYTE);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_index_reg <= sbus_fd_pkg::IDX_IDLE;
        end else begin
            byte_index_reg <= byte_index_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start_wr) begin
            start_ok_reg <= (data_byte == sbus_fd_pkg::START_BYTE);
        end
        if (wr_en) begin
            store_reg[wr_addr] <= data_byte;
        end
    end

    // payload bit p lives in frame byte 1 + p/8
    always_comb begin
        for (int b = 0; b < sbus_fd_pkg::STORE_LEN; b++) begin
            payload[b*8 +: 8] = store_reg[b];
        end
        for (int n = 0; n < sbus_fd_pkg::NUM_CHAN; n++) begin
            raw           = payload[n*sbus_fd_pkg::CHAN_W +: sbus_fd_pkg::CHAN_W];
            frame.chan[n] = {~raw[10], raw[9:0]};
        end
        for (int s = 0; s < sbus_fd_pkg::NUM_SW; s++) begin
            raw = payload[(s + sbus_fd_pkg::NUM_CHAN)*sbus_fd_pkg::CHAN_W +:
                          sbus_fd_pkg::CHAN_W];
            if (!raw[10]) begin
                frame.sw[s] = sbus_fd_pkg::SW_LOW;
            end else if (raw == sbus_fd_pkg::RAW_MID) begin
                frame.sw[s] = sbus_fd_pkg::SW_MID;
            end else begin
                frame.sw[s] = sbus_fd_pkg::SW_HIGH;
            end
        end
        frame.lost = store_reg[sbus_fd_pkg::FLAG_BYTE][sbus_fd_pkg::LOST_BIT];
        frame.fs   = store_reg[sbus_fd_pkg::FLAG_BYTE][sbus_fd_pkg::FS_BIT];
    end

endmodule

// File: rtl/sbus_fd_scale.sv
// ----------------------------------------------------------------------------
// SBUS channel scaler
// Two-stage rounded scaling of one centred channel: 660/783 for positive
// values, 660/784 for negative ones, by reciprocal multiply and correction.
// ----------------------------------------------------------------------------
module sbus_fd_scale (
    input  logic                  aclk,
    input  sbus_fd_pkg::pipe_en_t en,
    input  sbus_fd_pkg::chan_t    chan_in,
    output sbus_fd_pkg::chan_t    raw_out,
    output sbus_fd_pkg::chan_t    scaled_out
);

    logic [sbus_fd_pkg::MAG_W-1:0]   ext;
    logic [sbus_fd_pkg::MAG_W-1:0]   mag;
    logic [sbus_fd_pkg::NUM_W-1:0]   num_next;
    logic [sbus_fd_pkg::NUM_W-1:0]   num2_reg;
    logic                            neg2_reg;
    sbus_fd_pkg::chan_t              raw2_reg;

    logic [sbus_fd_pkg::RECIP_W-1:0] recip;
    logic [sbus_fd_pkg::PROD_W-1:0]  prod;
    logic [sbus_fd_pkg::QUO_W-1:0]   quo3_reg;
    logic [sbus_fd_pkg::NUM_W-1:0]   num3_reg;
    logic                            neg3_reg;
    sbus_fd_pkg::chan_t              raw3_reg;

    logic [sbus_fd_pkg::DIV_W-1:0]   div;
    logic [sbus_fd_pkg::NUM_W-1:0]   rem;
    logic [sbus_fd_pkg::QUO_W-1:0]   quo;

    // numerator 1320*|v| + 783; positive side floor(num / 1566), negative side -floor(num / 1568)
    always_comb begin
        ext      = {chan_in[sbus_fd_pkg::CHAN_W-1], chan_in};
        mag      = chan_in[sbus_fd_pkg::CHAN_W-1] ? (12'd0 - ext) : ext;
        num_next = sbus_fd_pkg::NUM_W'(32'(mag) * sbus_fd_pkg::SCALE_MUL
                                       + sbus_fd_pkg::ROUND_ADD);
    end

    always_ff @(posedge aclk) begin
        if (en.s2) begin
            num2_reg <= num_next;
            neg2_reg <= chan_in[sbus_fd_pkg::CHAN_W-1];
            raw2_reg <= chan_in;
        end
    end

    always_comb begin
        recip = neg2_reg ? sbus_fd_pkg::RECIP_NEG : sbus_fd_pkg::RECIP_POS;
        prod  = sbus_fd_pkg::PROD_W'(num2_reg) * sbus_fd_pkg::PROD_W'(recip);
    end

    always_ff @(posedge aclk) begin
        if (en.s3) begin
            quo3_reg <= prod[sbus_fd_pkg::RECIP_SHIFT +: sbus_fd_pkg::QUO_W];
            num3_reg <= num2_reg;
            neg3_reg <= neg2_reg;
            raw3_reg <= raw2_reg;
        end
    end

    // estimate is exact or one low
    always_comb begin
        div = neg3_reg ? sbus_fd_pkg::DIV_W'(sbus_fd_pkg::DIV_NEG)
                       : sbus_fd_pkg::DIV_W'(sbus_fd_pkg::DIV_POS);
        rem = num3_reg - sbus_fd_pkg::NUM_W'(32'(quo3_reg) * 32'(div));
        quo = quo3_reg + sbus_fd_pkg::QUO_W'(rem >= sbus_fd_pkg::NUM_W'(div));
        scaled_out = neg3_reg ? sbus_fd_pkg::chan_t'(11'd0 - {1'b0, quo})
                              : sbus_fd_pkg::chan_t'({1'b0, quo});
        raw_out    = raw3_reg;
    end

endmodule

// File: bench/sbus_frame_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SBUS frame decoder testbench
// Streams SBUS frame bytes into the decoder, predicts every decoded frame
// from its own copy of the frame store and byte counter, and checks each
// result item field by field. It covers directed extremes, framing errors,
// scaling on and off, and random traffic under several idle/stall mixes.
// ----------------------------------------------------------------------------
module sbus_frame_decoder_tb;

    localparam int FRAME_BYTES    = 25;
    localparam int FLAG_POS       = 23;
    localparam int NUM_RAW_CHAN   = 16;
    localparam int PAYLOAD_W      = NUM_RAW_CHAN * sbus_fd_pkg::CHAN_W;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_BYTES    = 320;

    typedef logic [FRAME_BYTES*8-1:0] sbus_frame_t;

    logic        aclk           = 1'b0;
    logic        aresetn        = 1'b0;
    logic        s_valid        = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte    = 8'h00;
    logic        s_frame_start  = 1'b0;
    logic        cfg_valid      = 1'b0;
    logic        cfg_ready;
    logic        cfg_map_enable = 1'b1;
    logic        m_valid;
    logic        m_ready        = 1'b0;
    sbus_fd_pkg::chan_t m_chan0, m_chan1, m_chan2, m_chan3, m_chan4, m_chan5;
    sbus_fd_pkg::sw_t   m_switch0, m_switch1, m_switch2, m_switch3;
    logic        m_lost_frame;
    logic        m_fail_safe;

    // decoder model state
    logic [7:0]  frame_mem [0:FLAG_POS];
    logic [4:0]  byte_pos;
    logic        map_enable_model;
    sbus_fd_pkg::frame_t decoded_frames_q [$];

    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          mismatch_count = 0;
    int          bytes_sent     = 0;
    int          frames_checked = 0;
    int          frames_rejected = 0;
    int          idle_cycles    = 0;

    sbus_frame_decoder i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .s_frame_start  (s_frame_start),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_map_enable (cfg_map_enable),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_chan0        (m_chan0),
        .m_chan1        (m_chan1),
        .m_chan2        (m_chan2),
        .m_chan3        (m_chan3),
        .m_chan4        (m_chan4),
        .m_chan5        (m_chan5),
        .m_switch0      (m_switch0),
        .m_switch1      (m_switch1),
        .m_switch2      (m_switch2),
        .m_switch3      (m_switch3),
        .m_lost_frame   (m_lost_frame),
        .m_fail_safe    (m_fail_safe)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Decoder model
    // ------------------------------------------------------------------------
    function automatic int raw_channel(input int n);
        int v;
        int p;
        int k;
        v = 0;
        for (k = 0; k < sbus_fd_pkg::CHAN_W; k++) begin
            p = n * sbus_fd_pkg::CHAN_W + k;
            if (frame_mem[1 + p / 8][p % 8])
                v |= 1 << k;
        end
        return v - int'(sbus_fd_pkg::RAW_MID);
    endfunction

    // round-half-up of v*660/783 (v >= 0) or v*660/784 (v < 0)
    function automatic int scale_stick(input int v);
        int num;
        int den;
        int q;
        if (v >= 0) begin
            num = sbus_fd_pkg::SCALE_MUL * v + sbus_fd_pkg::ROUND_ADD;
            den = sbus_fd_pkg::DIV_POS;
        end else begin
            num = sbus_fd_pkg::SCALE_MUL * v + sbus_fd_pkg::DIV_NEG / 2;
            den = sbus_fd_pkg::DIV_NEG;
        end
        q = num / den;
        if ((num % den) != 0 && num < 0)
            q--;
        return q;
    endfunction

    task automatic decode_byte(input logic [7:0] data, input logic start);
        sbus_fd_pkg::frame_t f;
        int     v;
        int     i;
        if (start) begin
            frame_mem[0] = data;
            byte_pos = 5'd1;
        end else if (byte_pos < sbus_fd_pkg::IDX_LAST) begin
            frame_mem[byte_pos] = data;
            byte_pos++;
        end else if (byte_pos == sbus_fd_pkg::IDX_LAST) begin
            byte_pos = sbus_fd_pkg::IDX_IDLE;
            if (frame_mem[0] != sbus_fd_pkg::START_BYTE || data != sbus_fd_pkg::END_BYTE) begin
                frames_rejected++;
            end else begin
                for (i = 0; i < sbus_fd_pkg::NUM_CHAN; i++) begin
                    v = raw_channel(i);
                    if (map_enable_model)
                        v = scale_stick(v);
                    f.chan[i] = sbus_fd_pkg::chan_t'(v);
                end
                for (i = 0; i < sbus_fd_pkg::NUM_SW; i++) begin
                    v = raw_channel(sbus_fd_pkg::NUM_CHAN + i);
                    f.sw[i] = (v < 0) ? sbus_fd_pkg::SW_LOW
                                      : ((v > 0) ? sbus_fd_pkg::SW_HIGH : sbus_fd_pkg::SW_MID);
                end
                f.lost = frame_mem[FLAG_POS][sbus_fd_pkg::LOST_BIT];
                f.fs   = frame_mem[FLAG_POS][sbus_fd_pkg::FS_BIT];
                decoded_frames_q.push_back(f);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------
    task automatic check_field(input string name, input int want_v, input int got_v);
        if (want_v != got_v) begin
            mismatch_count++;
            $display("%0t %s mismatch: expected %0d, actual %0d",
                     $time, name, want_v, got_v);
        end
    endtask

    always @(posedge aclk) begin : check_results
        sbus_fd_pkg::frame_t want;
        sbus_fd_pkg::frame_t got;
        int     i;
        if (aresetn && m_valid && m_ready) begin
            got.chan = {m_chan5, m_chan4, m_chan3, m_chan2, m_chan1, m_chan0};
            got.sw   = {m_switch3, m_switch2, m_switch1, m_switch0};
            got.lost = m_lost_frame;
            got.fs   = m_fail_safe;
            if (decoded_frames_q.size() == 0) begin
                mismatch_count++;
                $display("%0t unexpected result item: expected none, actual chan0 %0d",
                         $time, $signed(got.chan[0]));
            end else begin
                want = decoded_frames_q.pop_front();
                frames_checked++;
                for (i = 0; i < sbus_fd_pkg::NUM_CHAN; i++)
                    check_field($sformatf("chan%0d", i), $signed(want.chan[i]),
                                $signed(got.chan[i]));
                for (i = 0; i < sbus_fd_pkg::NUM_SW; i++)
                    check_field($sformatf("switch%0d", i), $signed(want.sw[i]),
                                $signed(got.sw[i]));
                check_field("lost_frame", want.lost, got.lost);
                check_field("fail_safe", want.fs, got.fs);
            end
        end
    end

    initial begin : watchdog
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t watchdog: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] data, input logic start);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid       <= 1'b1;
        s_data_byte   <= data;
        s_frame_start <= start;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        decode_byte(data, start);
        bytes_sent++;
    endtask

    task automatic send_head(input sbus_frame_t f, input int count);
        int k;
        for (k = 0; k < count; k++)
            send_byte(f[8*k +: 8], k == 0);
    endtask

    // hold the input side until every pending result has come out
    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (decoded_frames_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_map_enable(input logic en);
        wait_drained();
        @(negedge aclk);
        cfg_valid      <= 1'b1;
        cfg_map_enable <= en;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        map_enable_model = en;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic sbus_frame_t make_frame(input logic [PAYLOAD_W-1:0] payload,
                                               input logic [7:0] flags);
        return {sbus_fd_pkg::END_BYTE, flags, payload, sbus_fd_pkg::START_BYTE};
    endfunction

    function automatic logic [PAYLOAD_W-1:0] uniform_payload(
        input logic [sbus_fd_pkg::CHAN_W-1:0] c);
        logic [PAYLOAD_W-1:0] p;
        int                   n;
        for (n = 0; n < NUM_RAW_CHAN; n++)
            p[n*sbus_fd_pkg::CHAN_W +: sbus_fd_pkg::CHAN_W] = c;
        return p;
    endfunction

    function automatic logic [PAYLOAD_W-1:0] random_payload();
        logic [PAYLOAD_W-1:0]          p;
        logic [sbus_fd_pkg::CHAN_W-1:0] c;
        int                            n;
        for (n = 0; n < NUM_RAW_CHAN; n++) begin
            case ($urandom_range(7))
                0: c = '0;
                1: c = '1;
                2: c = sbus_fd_pkg::RAW_MID;
                3: c = sbus_fd_pkg::RAW_MID - 1'b1;
                4: c = sbus_fd_pkg::RAW_MID + 1'b1;
                default: c = sbus_fd_pkg::CHAN_W'($urandom);
            endcase
            p[n*sbus_fd_pkg::CHAN_W +: sbus_fd_pkg::CHAN_W] = c;
        end
        return p;
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_scaled_extremes();
        send_head(make_frame(uniform_payload(11'h000), 8'h00), FRAME_BYTES);
        send_head(make_frame(uniform_payload(11'h7FF), 8'h04), FRAME_BYTES);
        send_head(make_frame(uniform_payload(sbus_fd_pkg::RAW_MID), 8'h08), FRAME_BYTES);
        send_head(make_frame(uniform_payload(sbus_fd_pkg::RAW_MID - 1'b1), 8'h0C),
                  FRAME_BYTES);
        send_head(make_frame(uniform_payload(sbus_fd_pkg::RAW_MID + 1'b1), 8'hFF),
                  FRAME_BYTES);
        send_head(make_frame(random_payload(), 8'hF3), FRAME_BYTES);
    endtask

    task automatic test_raw_passthrough();
        set_map_enable(1'b0);
        send_head(make_frame(uniform_payload(11'h000), 8'h0C), FRAME_BYTES);
        send_head(make_frame(uniform_payload(11'h7FF), 8'h00), FRAME_BYTES);
        send_head(make_frame(uniform_payload(sbus_fd_pkg::RAW_MID), 8'h04), FRAME_BYTES);
        send_head(make_frame(random_payload(), 8'h08), FRAME_BYTES);
        set_map_enable(1'b1);
    endtask

    task automatic test_framing_errors();
        sbus_frame_t f;
        // stray bytes while idle
        send_byte(sbus_fd_pkg::START_BYTE, 1'b0);
        send_byte(8'hFF, 1'b0);
        // bad start byte
        f = make_frame(random_payload(), 8'h0C);
        f[7:0] = sbus_fd_pkg::START_BYTE ^ 8'h80;
        send_head(f, FRAME_BYTES);
        // bad end byte
        f = make_frame(random_payload(), 8'h04);
        f[8*FLAG_POS+8 +: 8] = 8'h01;
        send_head(f, FRAME_BYTES);
        // restart in mid-frame, and restart where the end byte is due
        send_head(make_frame(random_payload(), 8'h08), 12);
        send_head(make_frame(random_payload(), 8'h00), FRAME_BYTES - 1);
        send_head(make_frame(random_payload(), 8'h0C), FRAME_BYTES);
        // back-to-back good frames, then a byte with no frame start
        send_head(make_frame(random_payload(), 8'h04), FRAME_BYTES);
        send_head(make_frame(random_payload(), 8'h08), FRAME_BYTES);
        send_byte(sbus_fd_pkg::END_BYTE, 1'b0);
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input logic map_en, input int n_bytes);
        sbus_frame_t f;
        int          first;
        int          n;
        int          k;
        bit          paused;
        set_map_enable(map_en);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        first  = bytes_sent;
        paused = 1'b0;
        while (bytes_sent - first < n_bytes) begin
            if (!paused && bytes_sent - first >= n_bytes / 2) begin
                wait_drained();
                paused = 1'b1;
            end
            f = make_frame(random_payload(), 8'($urandom));
            n = $urandom_range(99);
            if (n < 70) begin
                send_head(f, FRAME_BYTES);
            end else if (n < 77) begin
                f[7:0] = 8'($urandom);
                send_head(f, FRAME_BYTES);
            end else if (n < 84) begin
                f[8*FLAG_POS+8 +: 8] = 8'($urandom);
                send_head(f, FRAME_BYTES);
            end else if (n < 92) begin
                send_head(f, $urandom_range(FRAME_BYTES - 1, 1));
            end else begin
                for (k = $urandom_range(6, 1); k > 0; k--)
                    send_byte(8'($urandom), $urandom_range(7) == 0);
            end
        end
    endtask

    initial begin : main
        byte_pos         = sbus_fd_pkg::IDX_IDLE;
        map_enable_model = 1'b1;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_scaled_extremes();
        test_raw_passthrough();
        test_framing_errors();
        test_random_traffic(0, 0, 1'b1, PHASE_BYTES);
        test_random_traffic(68, 0, 1'b0, PHASE_BYTES);
        test_random_traffic(0, 68, 1'b1, PHASE_BYTES);
        test_random_traffic(11, 11, 1'b0, PHASE_BYTES);

        wait_drained();
        if (decoded_frames_q.size() != 0) begin
            mismatch_count += decoded_frames_q.size();
            $display("%0t %0d expected result items never arrived",
                     $time, decoded_frames_q.size());
        end
        $display("Sent %0d frame bytes: %0d decoded frames checked, %0d rejected frames.",
                 bytes_sent, frames_checked, frames_rejected);
        $display("Scaling on and off, framing errors, four idle/stall mixes, %0d mismatches.",
                 mismatch_count);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
